FILE: sv/vvtcp_pkg.sv
// shared types, constants and helpers for the vertex view transform core
// no dependencies
`default_nettype none
package vvtcp_pkg;

	localparam int COEF_FRAC_BITS = 14;
	localparam int QBITS = 41;
	localparam logic [QBITS-1:0] QCLAMP = {1'b1, {(QBITS-1){1'b0}}};

	typedef enum logic [2:0] {
		REG_ROW_RIGHT   = 3'd0,
		REG_ROW_UP      = 3'd1,
		REG_ROW_FORWARD = 3'd2,
		REG_EYE_X       = 3'd3,
		REG_EYE_Y       = 3'd4,
		REG_EYE_Z       = 3'd5,
		REG_FAR_LIMIT   = 3'd6,
		REG_HALF_SCREEN = 3'd7
	} reg_idx_t;

	// per-item values that ride alongside the divider lanes
	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic [5:0]         cc;
		logic               proj;
		logic               zovf;
	} side_t;

	// one divider lane: partial remainder, numerator bits still to shift in, quotient so far
	typedef struct packed {
		logic [31:0]      rem;
		logic [QBITS-1:0] low;
		logic [QBITS-1:0] q;
		logic             neg;
		logic             big;
	} lane_t;

	function automatic logic signed [31:0] sat_to_32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: sv/vertex_view_transform_clip_project_core.sv
// throughput one beat per cycle while no finished beat is held at the output
// the quotient pipeline has 41 stages, one bit per stage per lane
// the whole pipeline advances together and holds while a finished beat waits
// reset clears every valid bit and loads the identity view, eye at origin,
// far limit at maximum and a 640 by 480 window
`default_nettype none
module vertex_view_transform_clip_project_core (
	input  wire                clk,
	input  wire                arst_n,
	// apb-style configuration
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [5:0]          paddr,
	input  wire [63:0]         pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	// input channel
	input  wire                in_valid,
	output logic               in_stall,
	input  wire signed [31:0]  world_x,
	input  wire signed [31:0]  world_y,
	input  wire signed [31:0]  world_z,
	// output channel
	output logic               out_valid,
	input  wire                out_stall,
	output logic signed [31:0] view_x,
	output logic signed [31:0] view_y,
	output logic signed [31:0] view_z,
	output logic [5:0]         clip_code,
	output logic signed [31:0] screen_x,
	output logic signed [31:0] screen_y,
	output logic               projected,
	output logic               overflow
);
	import vvtcp_pkg::*;

	// configuration registers
	logic [47:0]        row_right_q, row_up_q, row_forward_q;
	logic signed [31:0] eye_x_q, eye_y_q, eye_z_q;
	logic [30:0]        far_q;
	logic [31:0]        half_q;
	reg_idx_t           ridx;
	logic               wr;

	// pipeline
	logic               en;
	logic               v_s3;
	logic signed [31:0] vx_s3, vy_s3, vz_s3;
	logic               v_s4;
	side_t              sd_s4;
	logic signed [47:0] nx_s4, ny_s4;
	logic               dv;
	side_t              dside;
	lane_t              lx, ly;
	logic               out_valid_q;
	logic [5:0]         cc;
	logic [15:0]        w2, h2;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[5:3]);
	assign wr     = psel && penable && pwrite && pready;
	assign w2     = half_q[15:0];
	assign h2     = half_q[31:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_right_q   <= 48'h0000_0000_4000;
			row_up_q      <= 48'h0000_4000_0000;
			row_forward_q <= 48'h4000_0000_0000;
			eye_x_q       <= '0;
			eye_y_q       <= '0;
			eye_z_q       <= '0;
			far_q         <= 31'h7FFF_FFFF;
			half_q        <= {16'd240, 16'd320};
		end else if (wr) begin
			case (ridx)
				REG_ROW_RIGHT:   row_right_q   <= pwdata[47:0];
				REG_ROW_UP:      row_up_q      <= pwdata[47:0];
				REG_ROW_FORWARD: row_forward_q <= pwdata[47:0];
				REG_EYE_X:       eye_x_q       <= pwdata[31:0];
				REG_EYE_Y:       eye_y_q       <= pwdata[31:0];
				REG_EYE_Z:       eye_z_q       <= pwdata[31:0];
				REG_FAR_LIMIT:   far_q         <= pwdata[30:0];
				REG_HALF_SCREEN: half_q        <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (ridx)
			REG_ROW_RIGHT:   prdata = {16'b0, row_right_q};
			REG_ROW_UP:      prdata = {16'b0, row_up_q};
			REG_ROW_FORWARD: prdata = {16'b0, row_forward_q};
			REG_EYE_X:       prdata = {32'b0, eye_x_q};
			REG_EYE_Y:       prdata = {32'b0, eye_y_q};
			REG_EYE_Z:       prdata = {32'b0, eye_z_q};
			REG_FAR_LIMIT:   prdata = {33'b0, far_q};
			REG_HALF_SCREEN: prdata = {32'b0, half_q};
			default:         prdata = '0;
		endcase
	end

	// the pipeline moves unless a finished beat is held at the output
	assign en        = !(out_valid_q && out_stall);
	assign in_stall  = !en;
	assign out_valid = out_valid_q;

	// stages 1 to 3: offset and rotation
	vvtcp_xform u_xform (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (in_valid),
		.world_x     (world_x),
		.world_y     (world_y),
		.world_z     (world_z),
		.eye_x       (eye_x_q),
		.eye_y       (eye_y_q),
		.eye_z       (eye_z_q),
		.row_right   (row_right_q),
		.row_up      (row_up_q),
		.row_forward (row_forward_q),
		.v_s3        (v_s3),
		.vx_s3       (vx_s3),
		.vy_s3       (vy_s3),
		.vz_s3       (vz_s3)
	);

	// stage 4: outcodes against the saturated view values, and the projection numerators
	always_comb begin
		logic signed [32:0] nz;
		nz    = -$signed({vz_s3[31], vz_s3});
		cc[0] = vx_s3 > vz_s3;
		cc[1] = vy_s3 > vz_s3;
		cc[2] = $signed({vx_s3[31], vx_s3}) < nz;
		cc[3] = $signed({vy_s3[31], vy_s3}) < nz;
		cc[4] = vz_s3[31];
		cc[5] = vz_s3 > $signed({1'b0, far_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s4.vx   <= vx_s3;
			sd_s4.vy   <= vy_s3;
			sd_s4.vz   <= vz_s3;
			sd_s4.cc   <= cc;
			sd_s4.proj <= !vz_s3[31];
			sd_s4.zovf <= vz_s3 == 32'sd0;
			nx_s4      <= vx_s3 * $signed({1'b0, w2});
			ny_s4      <= vy_s3 * $signed({1'b0, h2});
		end
	end

	// quotient pipeline: magnitude times 2^16 over depth, both lanes together
	vvtcp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s4),
		.num_x    (nx_s4),
		.num_y    (ny_s4),
		.side_in  (sd_s4),
		.v_out    (dv),
		.side_out (dside),
		.lane_x   (lx),
		.lane_y   (ly)
	);

	// last stage: clamp the quotient, add the window centre, saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= dv;
	end

	always_ff @(posedge clk) begin
		logic [QBITS-1:0]   mx, my;
		logic signed [42:0] qx, qy, cx, cy;
		logic signed [31:0] sx, sy;
		if (en) begin
			mx = (lx.big || lx.q > QCLAMP) ? QCLAMP : lx.q;
			my = (ly.big || ly.q > QCLAMP) ? QCLAMP : ly.q;
			qx = lx.neg ? -$signed({2'b0, mx}) : $signed({2'b0, mx});
			qy = ly.neg ? -$signed({2'b0, my}) : $signed({2'b0, my});
			cx = $signed({11'b0, w2, 16'b0}) + qx;
			cy = $signed({11'b0, h2, 16'b0}) - qy;
			sx = sat_to_32(64'(cx));
			sy = sat_to_32(64'(cy));
			view_x    <= dside.vx;
			view_y    <= dside.vy;
			view_z    <= dside.vz;
			clip_code <= dside.cc;
			projected <= dside.proj;
			if (dside.proj) begin
				screen_x <= sx;
				screen_y <= sy;
				overflow <= dside.zovf || (64'(sx) != 64'(cx)) || (64'(sy) != 64'(cy));
			end else begin
				screen_x <= '0;
				screen_y <= '0;
				overflow <= 1'b0;
			end
		end
	end

	// a held beat stays on the port
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// points behind the eye leave the screen fields clear
	a_behind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !projected |-> screen_x == 32'sd0 && screen_y == 32'sd0 && !overflow)
		else $error("behind point carries screen data");

	// projected and behind outcode agree
	a_proj: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> projected == !clip_code[4])
		else $error("projected flag disagrees with behind outcode");

	// zero depth always flags overflow
	a_zdepth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && view_z == 32'sd0 |-> overflow)
		else $error("zero depth without overflow");

endmodule
`default_nettype wire

FILE: sv/vvtcp_xform.sv
// eye offset, matrix products and rounded dot products (three stages)
// depends on vvtcp_pkg
`default_nettype none
module vvtcp_xform (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                en,
	input  wire                in_valid,
	input  wire signed [31:0]  world_x,
	input  wire signed [31:0]  world_y,
	input  wire signed [31:0]  world_z,
	input  wire signed [31:0]  eye_x,
	input  wire signed [31:0]  eye_y,
	input  wire signed [31:0]  eye_z,
	input  wire [47:0]         row_right,
	input  wire [47:0]         row_up,
	input  wire [47:0]         row_forward,
	output logic               v_s3,
	output logic signed [31:0] vx_s3,
	output logic signed [31:0] vy_s3,
	output logic signed [31:0] vz_s3
);
	import vvtcp_pkg::*;

	localparam logic signed [51:0] ROUND = 52'sd1 <<< (COEF_FRAC_BITS - 1);

	logic               v_s1, v_s2;
	logic signed [32:0] d_s1 [3];
	logic signed [48:0] p_s2 [3][3];
	logic [47:0]        rows [3];
	logic signed [31:0] dot  [3];

	assign rows[0] = row_right;
	assign rows[1] = row_up;
	assign rows[2] = row_forward;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: offset from the eye
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= $signed({world_x[31], world_x}) - $signed({eye_x[31], eye_x});
			d_s1[1] <= $signed({world_y[31], world_y}) - $signed({eye_y[31], eye_y});
			d_s1[2] <= $signed({world_z[31], world_z}) - $signed({eye_z[31], eye_z});
		end
	end

	// stage 2: nine products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					p_s2[r][k] <= d_s1[k] * $signed(rows[r][16*k +: 16]);
				end
			end
		end
	end

	// stage 3: sum, round half up, floor shift, saturate
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			logic signed [51:0] acc;
			logic signed [51:0] sh;
			acc = 52'(p_s2[r][0]) + 52'(p_s2[r][1]) + 52'(p_s2[r][2]) + ROUND;
			sh  = acc >>> COEF_FRAC_BITS;
			dot[r] = sat_to_32(64'(sh));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s3 <= dot[0];
			vy_s3 <= dot[1];
			vz_s3 <= dot[2];
		end
	end

endmodule
`default_nettype wire

FILE: sv/vvtcp_div.sv
// two-lane restoring divider, one quotient bit per stage, with sideband
// depends on vvtcp_pkg
`default_nettype none
module vvtcp_div (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                en,
	input  wire                v_in,
	input  wire signed [47:0]  num_x,
	input  wire signed [47:0]  num_y,
	input  vvtcp_pkg::side_t   side_in,
	output logic               v_out,
	output vvtcp_pkg::side_t   side_out,
	output vvtcp_pkg::lane_t   lane_x,
	output vvtcp_pkg::lane_t   lane_y
);
	import vvtcp_pkg::*;

	logic  v_s  [0:QBITS];
	side_t sd_s [0:QBITS];
	lane_t ln_s [0:QBITS][2];
	lane_t ent  [2];

	function automatic lane_t enter(input logic signed [47:0] num, input logic [30:0] z);
		lane_t l;
		logic [47:0] mag;
		logic [62:0] n;
		mag   = num[47] ? 48'(-num) : 48'(num);
		n     = {mag[46:0], 16'b0};
		l.neg = num[47];
		l.big = (num != 48'sd0) && ({9'b0, n[62:QBITS]} >= z);
		l.rem = {10'b0, n[62:QBITS]};
		l.low = n[QBITS-1:0];
		l.q   = '0;
		return l;
	endfunction

	// a zero depth yields no quotient bits, so a zero numerator stays at zero
	function automatic lane_t step(input lane_t l, input logic [30:0] z);
		lane_t o;
		logic [31:0] trial;
		logic ge;
		trial = {l.rem[30:0], l.low[QBITS-1]};
		ge    = (z != 31'd0) && (trial >= {1'b0, z});
		o     = l;
		o.rem = ge ? trial - {1'b0, z} : trial;
		o.low = {l.low[QBITS-2:0], 1'b0};
		o.q   = {l.q[QBITS-2:0], ge};
		return o;
	endfunction

	assign ent[0] = enter(num_x, side_in.vz[30:0]);
	assign ent[1] = enter(num_y, side_in.vz[30:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else if (en)
			v_s[0] <= v_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[0]    <= side_in;
			ln_s[0][0] <= ent[0];
			ln_s[0][1] <= ent[1];
		end
	end

	for (genvar g = 1; g <= QBITS; g++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[g] <= 1'b0;
			else if (en)
				v_s[g] <= v_s[g-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[g]    <= sd_s[g-1];
				ln_s[g][0] <= step(ln_s[g-1][0], sd_s[g-1].vz[30:0]);
				ln_s[g][1] <= step(ln_s[g-1][1], sd_s[g-1].vz[30:0]);
			end
		end
	end

	assign v_out    = v_s[QBITS];
	assign side_out = sd_s[QBITS];
	assign lane_x   = ln_s[QBITS][0];
	assign lane_y   = ln_s[QBITS][1];

endmodule
`default_nettype wire

FILE: dv/vvtcp_checker.sv
// result checker for the vertex view transform core: mirrors the register file,
// predicts every output beat from the accepted input beats and compares field by field
// depends on vvtcp_pkg for the register indexes and the coefficient fraction width
`default_nettype none
module vvtcp_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire               pready,
	input  wire [5:0]         paddr,
	input  wire [63:0]        pwdata,
	input  wire               in_valid,
	input  wire               in_stall,
	input  wire [31:0]        world_x,
	input  wire [31:0]        world_y,
	input  wire [31:0]        world_z,
	input  wire               out_valid,
	input  wire               out_stall,
	input  wire [31:0]        view_x,
	input  wire [31:0]        view_y,
	input  wire [31:0]        view_z,
	input  wire [5:0]         clip_code,
	input  wire [31:0]        screen_x,
	input  wire [31:0]        screen_y,
	input  wire               projected,
	input  wire               overflow,
	output int                fail_count,
	output int                pending_count
);
	import vvtcp_pkg::*;

	typedef struct {
		logic [31:0] vx, vy, vz;
		logic [5:0]  cc;
		logic [31:0] sx, sy;
		logic        proj, ovf;
	} vertex_t;

	localparam longint QLIM = longint'(1) << 40;

	vertex_t     vertex_q[$];
	logic [47:0] m_right, m_up, m_fwd;
	longint      m_eye[3];
	longint      m_far;
	logic [31:0] m_half;
	int          fails = 0;

	function automatic longint clamp32(longint v, ref bit hit);
		if (v > 64'sd2147483647) begin
			hit = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			hit = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint row_dot(logic [47:0] row, longint d[3]);
		longint acc;
		bit     dummy;
		acc = 0;
		for (int k = 0; k < 3; k++)
			acc += d[k] * longint'($signed(row[16*k +: 16]));
		acc += longint'(1) << (COEF_FRAC_BITS - 1);
		acc = acc >>> COEF_FRAC_BITS;
		return clamp32(acc, dummy);
	endfunction

	// numerator times 2^16 over a non-negative depth, truncated and clamped
	function automatic longint screen_quot(longint num, longint z);
		logic [63:0] mag;
		if (num == 0)
			return 0;
		if (z == 0)
			return (num < 0) ? -QLIM : QLIM;
		mag = (num < 0) ? 64'(-num) : 64'(num);
		mag = (mag << 16) / 64'(z);
		if (mag > 64'(QLIM))
			mag = 64'(QLIM);
		return (num < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic vertex_t project_vertex(logic [31:0] wx, logic [31:0] wy,
		logic [31:0] wz);
		vertex_t r;
		longint  d[3];
		longint  x, y, z, w2, h2, sx, sy;
		bit      ovf;
		d[0] = longint'($signed(wx)) - m_eye[0];
		d[1] = longint'($signed(wy)) - m_eye[1];
		d[2] = longint'($signed(wz)) - m_eye[2];
		x = row_dot(m_right, d);
		y = row_dot(m_up, d);
		z = row_dot(m_fwd, d);
		w2 = longint'(m_half[15:0]);
		h2 = longint'(m_half[31:16]);
		r.cc = {z > m_far, z < 0, y < -z, x < -z, y > z, x > z};
		sx = 0;
		sy = 0;
		ovf = 0;
		if (z >= 0) begin
			ovf = (z == 0);
			sx = clamp32((w2 << 16) + screen_quot(x * w2, z), ovf);
			sy = clamp32((h2 << 16) - screen_quot(y * h2, z), ovf);
		end
		r.vx = x[31:0];
		r.vy = y[31:0];
		r.vz = z[31:0];
		r.sx = sx[31:0];
		r.sy = sy[31:0];
		r.proj = (z >= 0);
		r.ovf = ovf;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		fails++;
	endtask

	assign pending_count = vertex_q.size();
	assign fail_count    = fails;

	always @(posedge clk or negedge arst_n) begin
		vertex_t e;
		if (!arst_n) begin
			m_right = 48'h4000;
			m_up = 48'h4000 << 16;
			m_fwd = 48'h4000 << 32;
			m_eye[0] = 0;
			m_eye[1] = 0;
			m_eye[2] = 0;
			m_far = 64'h7FFFFFFF;
			m_half = {16'd240, 16'd320};
			vertex_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (vertex_q.size() == 0) begin
					report_mismatch("output beat with none expected, view_x", view_x, 32'h0);
				end else begin
					e = vertex_q.pop_front();
					if (view_x !== e.vx) report_mismatch("view_x", view_x, e.vx);
					if (view_y !== e.vy) report_mismatch("view_y", view_y, e.vy);
					if (view_z !== e.vz) report_mismatch("view_z", view_z, e.vz);
					if (clip_code !== e.cc)
						report_mismatch("clip_code", 32'(clip_code), 32'(e.cc));
					if (screen_x !== e.sx) report_mismatch("screen_x", screen_x, e.sx);
					if (screen_y !== e.sy) report_mismatch("screen_y", screen_y, e.sy);
					if (projected !== e.proj)
						report_mismatch("projected", 32'(projected), 32'(e.proj));
					if (overflow !== e.ovf)
						report_mismatch("overflow", 32'(overflow), 32'(e.ovf));
				end
			end
			if (in_valid && !in_stall)
				vertex_q.push_back(project_vertex(world_x, world_y, world_z));
			if (psel && penable && pwrite && pready) begin
				case (paddr[5:3])
					REG_ROW_RIGHT:   m_right = pwdata[47:0];
					REG_ROW_UP:      m_up = pwdata[47:0];
					REG_ROW_FORWARD: m_fwd = pwdata[47:0];
					REG_EYE_X:       m_eye[0] = longint'($signed(pwdata[31:0]));
					REG_EYE_Y:       m_eye[1] = longint'($signed(pwdata[31:0]));
					REG_EYE_Z:       m_eye[2] = longint'($signed(pwdata[31:0]));
					REG_FAR_LIMIT:   m_far = longint'(pwdata[30:0]);
					REG_HALF_SCREEN: m_half = pwdata[31:0];
					default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

FILE: dv/tb_vertex_view_transform_clip_project_core.sv
// testbench top for the vertex view transform core: clock, reset, register
// programming, vertex stimulus under varied idling, watchdog and verdict
// depends on vvtcp_pkg, vvtcp_checker and the core itself
`default_nettype none
module tb_vertex_view_transform_clip_project_core;
	import vvtcp_pkg::*;

	localparam int LATENCY   = 47;
	localparam int WDOG_MAX  = 20000;
	localparam int HOLD_LONG = 300;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               psel = 0, penable = 0, pwrite = 0;
	logic [5:0]         paddr = '0;
	logic [63:0]        pwdata = '0;
	logic [63:0]        prdata;
	logic               pready;
	logic               in_valid = 0;
	logic               in_stall;
	logic signed [31:0] world_x = '0, world_y = '0, world_z = '0;
	logic               out_valid;
	logic               out_stall = 0;
	logic signed [31:0] view_x, view_y, view_z, screen_x, screen_y;
	logic [5:0]         clip_code;
	logic               projected, overflow;
	int                 fail_count, pending_count;

	// idling percentages per side, changed by the stimulus between phases
	int                 send_idle_pct = 0;
	int                 recv_idle_pct = 0;
	bit                 hold_recv = 0;
	int                 quiet_cycles = 0;

	always #10 clk = ~clk;

	vertex_view_transform_clip_project_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.world_x(world_x), .world_y(world_y), .world_z(world_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.view_x(view_x), .view_y(view_y), .view_z(view_z), .clip_code(clip_code),
		.screen_x(screen_x), .screen_y(screen_y),
		.projected(projected), .overflow(overflow)
	);

	vvtcp_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.world_x(world_x), .world_y(world_y), .world_z(world_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.view_x(view_x), .view_y(view_y), .view_z(view_z), .clip_code(clip_code),
		.screen_x(screen_x), .screen_y(screen_y),
		.projected(projected), .overflow(overflow),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	// receiver stall: random by percentage, or held solid for a long stretch
	always @(posedge clk)
		out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);

	// long receiver hold-off, counted in its own process
	task automatic hold_receiver();
		hold_recv = 1;
		repeat (HOLD_LONG) @(posedge clk);
		hold_recv = 0;
	endtask

	// watchdog: cycles with no beat accepted on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_MAX) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// register write, setup then access
	task automatic write_reg(reg_idx_t idx, logic [63:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	// drive one vertex beat and wait until it is taken; valid stays high across beats unless idling is drawn
	task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		world_x <= x;
		world_y <= y;
		world_z <= z;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// a random coordinate: mostly modest values, sometimes any 32 bits
	function automatic logic [31:0] rand_coord();
		if ($urandom_range(3) == 0)
			return $urandom;
		return 32'($signed($urandom_range(2000000)) - 1000000) << $urandom_range(8);
	endfunction

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(4))
			0: return 16'h4000;
			1: return 16'hC000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_setting();
		write_reg(REG_ROW_RIGHT, {16'h0, rand_coef(), rand_coef(), rand_coef()});
		write_reg(REG_ROW_UP, {16'h0, rand_coef(), rand_coef(), rand_coef()});
		write_reg(REG_ROW_FORWARD, {16'h0, rand_coef(), rand_coef(), rand_coef()});
		write_reg(REG_EYE_X, {32'h0, rand_coord()});
		write_reg(REG_EYE_Y, {32'h0, rand_coord()});
		write_reg(REG_EYE_Z, {32'h0, rand_coord()});
		write_reg(REG_FAR_LIMIT, {$urandom, $urandom});
		write_reg(REG_HALF_SCREEN, {$urandom, $urandom});
	endtask

	task automatic random_vertices(int n);
		for (int i = 0; i < n; i++)
			send_vertex(rand_coord(), rand_coord(), rand_coord());
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset view, field extremes, depth zero, behind, far, huge quotients
		send_vertex(32'h0, 32'h0, 32'h0);
		send_vertex(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_vertex(32'h80000000, 32'h80000000, 32'h80000000);
		send_vertex(32'h00010000, 32'hFFFF0000, 32'h0);
		send_vertex(32'h00010000, 32'h00010000, 32'hFFFF0000);
		send_vertex(32'h7FFFFFFF, 32'h80000000, 32'h00000001);
		send_vertex(32'h00050000, 32'h00050000, 32'h00010000);
		send_vertex(32'hFFFB0000, 32'hFFFB0000, 32'h00010000);
		send_vertex(32'h00002000, 32'hFFFFE000, 32'h00000000);
		send_vertex(32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF);
		drain();

		// extreme setting: extreme coefficients, far eye, tiny far limit, largest window
		write_reg(REG_ROW_RIGHT, 64'h0000_7FFF_7FFF_7FFF);
		write_reg(REG_ROW_UP, 64'h0000_8000_8000_8000);
		write_reg(REG_ROW_FORWARD, 64'h0000_4000_7FFF_8000);
		write_reg(REG_EYE_X, 64'hFFFF_FFFF_8000_0000);
		write_reg(REG_EYE_Y, 64'h0000_0000_7FFF_FFFF);
		write_reg(REG_EYE_Z, 64'h0000_0000_0000_0000);
		write_reg(REG_FAR_LIMIT, 64'h0000_0000_0000_0000);
		write_reg(REG_HALF_SCREEN, 64'hFFFF_FFFF_FFFF_FFFF);
		send_vertex(32'h0, 32'h0, 32'h0);
		send_vertex(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		send_vertex(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
		send_vertex(32'h00010000, 32'h00010000, 32'h00010000);
		drain();

		// identity with a small far limit so far and screen clipping both show up
		write_reg(REG_ROW_RIGHT, 64'h4000);
		write_reg(REG_ROW_UP, 64'h4000 << 16);
		write_reg(REG_ROW_FORWARD, 64'h4000 << 32);
		write_reg(REG_EYE_X, 64'h0);
		write_reg(REG_EYE_Y, 64'h0);
		write_reg(REG_EYE_Z, 64'h0);
		write_reg(REG_FAR_LIMIT, 64'h0064_0000);
		write_reg(REG_HALF_SCREEN, {32'h0, 16'd240, 16'd320});
		send_idle_pct = 16;
		recv_idle_pct = 76;
		random_vertices(200);

		// long receiver hold-off while vertices keep coming
		fork
			hold_receiver();
			random_vertices(120);
		join
		drain();

		random_setting();
		send_idle_pct = 76;
		recv_idle_pct = 16;
		random_vertices(200);
		drain();

		random_setting();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_vertices(150);
		drain();

		random_setting();
		random_vertices(150);
		drain();

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
sv/vvtcp_pkg.sv
sv/vvtcp_xform.sv
sv/vvtcp_div.sv
sv/vertex_view_transform_clip_project_core.sv
dv/vvtcp_checker.sv
dv/tb_vertex_view_transform_clip_project_core.sv
